### sv/ipv4dq_pkg.sv
// Shared types and constants for the IPv4 dotted-quad text parser.
// No dependencies; the parser RTL files and the testbench import this package, the checker does not.
`default_nettype none

package ipv4dq_pkg;

   localparam int unsigned CH_W       = 8;
   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned DCNT_W     = 2;
   localparam int unsigned OCTV_W     = 10;
   localparam int unsigned OIDX_W     = 3;
   localparam int unsigned DIGIT_W    = 4;

   localparam logic [CH_W-1:0]    CHAR_DOT    = 8'h2E;
   localparam logic [CH_W-1:0]    CHAR_ZERO   = 8'h30;
   localparam logic [CH_W-1:0]    CHAR_NINE   = 8'h39;
   localparam logic [OIDX_W-1:0]  FIELD_COUNT = 3'd4;
   localparam logic [DCNT_W-1:0]  MAX_DIGITS  = 2'd3;
   localparam logic [OCTV_W-1:0]  OCTET_MAX   = 10'd255;

   // One input character with its end-of-string flag
   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            last;
   } req_word_type;

   // One parse result
   typedef struct packed {
      logic              valid_res;
      logic [ADDR_W-1:0] address;
   } rsp_word_type;

endpackage

`default_nettype wire

### sv/ipv4_dotted_quad_parser.sv
// IPv4 dotted-quad parser, top level.
// Uses ipv4dq_pkg, ipv4dq_in_stage, ipv4dq_core and ipv4dq_out_stage.
//
// Usage:
//   req channel: one ASCII character per word (req_ch), req_last on the final
//   character of the string. rsp channel: one word per string, rsp_valid_res
//   and rsp_address (first octet in the top byte, zero when invalid).
//   Non-final characters produce no rsp word.
// Path: a final character passes two register stages, the input register
//   and then the result register, before its rsp word is visible.
// Throughput: one character per cycle while no final character is stalled; the per-character update
//   is one small multiply-by-ten, accumulate and compare between registers.
// Stall: while the result register is full and not taken, a non-final
//   character still moves through; a final character waits in the input
//   register and req_ready drops until the result is taken.
// Reset: synchronous, active high; clears both stages and all parser state,
//   req_ready is low during reset.
`default_nettype none

module ipv4_dotted_quad_parser (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_ch,
   input  wire         req_last,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_valid_res,
   output logic [31:0] rsp_address
);
   import ipv4dq_pkg::*;

   req_word_type req_word, in_word;
   rsp_word_type core_result, out_word;
   logic         in_valid, advance, req_load, can_load;

   assign req_word.ch   = req_ch;
   assign req_word.last = req_last;

   // Word leaves the input register unless it is final and the result slot is busy
   assign advance   = in_valid && (!in_word.last || can_load);
   assign req_ready = !reset && (!in_valid || advance);
   assign req_load  = req_valid && req_ready;

   ipv4dq_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .load       (req_load),
      .word_in    (req_word),
      .advance    (advance),
      .word_valid (in_valid),
      .word_out   (in_word)
   );

   ipv4dq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .word   (in_word),
      .result (core_result)
   );

   ipv4dq_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && in_word.last),
      .result     (core_result),
      .take       (rsp_ready),
      .can_load   (can_load),
      .word_valid (rsp_valid),
      .word_out   (out_word)
   );

   assign rsp_valid_res = out_word.valid_res;
   assign rsp_address   = out_word.address;

endmodule

`default_nettype wire

### sv/ipv4dq_in_stage.sv
// Input register stage: captures one character word per cycle when load is high; the word stays until advance.
// Depends on ipv4dq_pkg for the word type.
`default_nettype none

module ipv4dq_in_stage (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        load,
   input  ipv4dq_pkg::req_word_type   word_in,
   input  wire                        advance,
   output logic                       word_valid,
   output ipv4dq_pkg::req_word_type   word_out
);
   import ipv4dq_pkg::*;

   logic         valid_ff, valid_in;
   req_word_type word_ff;

   // Valid flag: set on load, cleared when the word moves on
   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign word_valid = valid_ff;
   assign word_out   = word_ff;

endmodule

`default_nettype wire

### sv/ipv4dq_core.sv
// Parser state and per-character update; forms the result on the final character.
// Depends on ipv4dq_pkg for constants and word types.
`default_nettype none

module ipv4dq_core (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        step,
   input  ipv4dq_pkg::req_word_type   word,
   output ipv4dq_pkg::rsp_word_type   result
);
   import ipv4dq_pkg::*;

   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [OCTV_W-1:0] octv_ff, octv_in;
   logic              fzero_ff, fzero_in;
   logic [OIDX_W-1:0] oidx_ff, oidx_in;
   logic [ADDR_W-1:0] accum_ff, accum_in;
   logic              bad_ff, bad_in;

   logic               is_dot, is_digit, do_close, close_ok;
   logic [DIGIT_W-1:0] digit;
   logic [OCTV_W-1:0]  times_ten;
   logic [DCNT_W-1:0]  dcnt_s;
   logic [OCTV_W-1:0]  octv_s;
   logic               fzero_s, bad_s;

   assign is_dot   = (word.ch == CHAR_DOT);
   assign is_digit = (word.ch >= CHAR_ZERO) && (word.ch <= CHAR_NINE);
   assign digit    = DIGIT_W'(word.ch - CHAR_ZERO);
   assign times_ten = OCTV_W'({octv_ff, 3'b000}) + OCTV_W'({octv_ff, 1'b0});

   // Digit / foreign character step on the current field
   always_comb begin
      dcnt_s  = dcnt_ff;
      octv_s  = octv_ff;
      fzero_s = fzero_ff;
      bad_s   = bad_ff;
      if (is_digit) begin
         if (dcnt_ff >= MAX_DIGITS) begin
            bad_s = 1'b1;
         end else begin
            if (dcnt_ff == '0) begin
               fzero_s = (digit == '0);
            end else if (fzero_ff) begin
               bad_s = 1'b1;
            end
            octv_s = times_ten + OCTV_W'(digit);
            dcnt_s = dcnt_ff + DCNT_W'(1);
         end
      end else if (!is_dot) begin
         bad_s = 1'b1;
      end
   end

   // Field close: on a dot, or at the end of the string
   assign do_close = is_dot || word.last;
   assign close_ok = (dcnt_s != '0) && (octv_s <= OCTET_MAX) && (oidx_ff < FIELD_COUNT);

   always_comb begin
      dcnt_in  = dcnt_s;
      octv_in  = octv_s;
      fzero_in = fzero_s;
      oidx_in  = oidx_ff;
      accum_in = accum_ff;
      bad_in   = bad_s;
      if (do_close) begin
         dcnt_in  = '0;
         octv_in  = '0;
         fzero_in = 1'b0;
         if (close_ok) begin
            accum_in = {accum_ff[ADDR_W-9:0], octv_s[7:0]};
            oidx_in  = oidx_ff + OIDX_W'(1);
         end else begin
            bad_in = 1'b1;
         end
      end
      // trailing dot
      if (is_dot && word.last) begin
         bad_in = 1'b1;
      end
   end

   // Result of the final character
   always_comb begin
      result.valid_res = !bad_in && (oidx_in == FIELD_COUNT);
      result.address   = result.valid_res ? accum_in : '0;
   end

   // State registers; cleared after each string
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff  <= '0;
         octv_ff  <= '0;
         fzero_ff <= 1'b0;
         oidx_ff  <= '0;
         accum_ff <= '0;
         bad_ff   <= 1'b0;
      end else if (step) begin
         if (word.last) begin
            dcnt_ff  <= '0;
            octv_ff  <= '0;
            fzero_ff <= 1'b0;
            oidx_ff  <= '0;
            accum_ff <= '0;
            bad_ff   <= 1'b0;
         end else begin
            dcnt_ff  <= dcnt_in;
            octv_ff  <= octv_in;
            fzero_ff <= fzero_in;
            oidx_ff  <= oidx_in;
            accum_ff <= accum_in;
            bad_ff   <= bad_in;
         end
      end
   end

endmodule

`default_nettype wire

### sv/ipv4dq_out_stage.sv
// Result register: holds one result word until the receiver takes it.
// Depends on ipv4dq_pkg for the result type.
`default_nettype none

module ipv4dq_out_stage (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        load,
   input  ipv4dq_pkg::rsp_word_type   result,
   input  wire                        take,
   output logic                       can_load,
   output logic                       word_valid,
   output ipv4dq_pkg::rsp_word_type   word_out
);
   import ipv4dq_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   assign can_load = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   assign word_valid = valid_ff;
   assign word_out   = word_ff;

endmodule

`default_nettype wire

### sv/ipv4dq_checker.sv
// Port-level checker for the IPv4 dotted-quad parser, with its bind.
// Depends on the top level ipv4_dotted_quad_parser port list.
`default_nettype none

module ipv4dq_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire [7:0]  req_ch,
   input wire        req_last,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire        rsp_valid_res,
   input wire [31:0] rsp_address
);

   // Stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_address)
         && $stable(rsp_valid_res))
      else $error("rsp word changed while stalled");

   // Invalid string reports a zero address
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_address == 32'd0)
      else $error("nonzero address on invalid result");

   // A fresh result follows an accepted final character through the input register and the result register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2))
      else $error("result without a matching final character");

   // Empty result register never stalls the input
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty result register");

endmodule

bind ipv4_dotted_quad_parser ipv4dq_checker u_ipv4dq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_ch        (req_ch),
   .req_last      (req_last),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_valid_res (rsp_valid_res),
   .rsp_address   (rsp_address)
);

`default_nettype wire

### tb/ipv4_dotted_quad_parser_tb.sv
// Self-checking testbench for ipv4_dotted_quad_parser: directed strings, then random text.
// Depends on ipv4dq_pkg and the parser RTL; expected words are typed-in rows or come from a local parse model.

module ipv4_dotted_quad_parser_tb;
   import ipv4dq_pkg::*;

   // One string's reference: a typed-in result word, or none (use the local parser model)
   typedef struct {
      bit           typed;
      rsp_word_type word;
   } quad_check_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_ch = 8'h00;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_valid_res;
   logic [31:0] rsp_address;

   // Local parser state, one string at a time
   logic [DCNT_W-1:0] cur_digits    = '0;
   logic [OCTV_W-1:0] cur_value     = '0;
   logic              cur_lead_zero = 1'b0;
   logic [OIDX_W-1:0] fields_done   = '0;
   logic [ADDR_W-1:0] addr_so_far   = '0;
   logic              str_bad       = 1'b0;

   rsp_word_type   addr_expect_q[$];
   quad_check_type str_ref_q[$];
   logic [7:0]     text_q[$];
   int unsigned    err_count   = 0;
   int unsigned    chars_sent  = 0;
   bit             send_jitter = 1'b1;
   bit             recv_jitter = 1'b1;

   // Directed strings; the last row is checked against the parser model
   localparam int DIR_ROWS = 12;
   string dir_text [DIR_ROWS] = '{
      "255.255.255.255", "0.0.0.0", ".", "1234", "01", "256", "a", "1.",
      "1.2.3.4.5", "7", "\377", "10.0.200.7"};
   bit dir_typed [DIR_ROWS] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0};
   rsp_word_type dir_rsp [DIR_ROWS] = '{
      {1'b1, 32'hFFFF_FFFF}, {1'b1, 32'h0000_0000}, {1'b0, 32'h0}, {1'b0, 32'h0},
      {1'b0, 32'h0}, {1'b0, 32'h0}, {1'b0, 32'h0}, {1'b0, 32'h0},
      {1'b0, 32'h0}, {1'b0, 32'h0}, {1'b0, 32'h0}, {1'b0, 32'h0}};

   ipv4_dotted_quad_parser dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_ch        (req_ch),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_valid_res (rsp_valid_res),
      .rsp_address   (rsp_address)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Close the current field: shift it into the address or flag the string
   function automatic void close_field();
      if (cur_digits == 0 || cur_value > OCTET_MAX || fields_done >= FIELD_COUNT) begin
         str_bad = 1'b1;
      end else begin
         addr_so_far = {addr_so_far[ADDR_W-9:0], cur_value[7:0]};
         fields_done = fields_done + OIDX_W'(1);
      end
      cur_digits    = '0;
      cur_value     = '0;
      cur_lead_zero = 1'b0;
   endfunction

   // Feed one character; returns 1 with the result word on the final character
   function automatic bit parse_char(input logic [7:0] c, input logic fin,
                                     output rsp_word_type res);
      logic [3:0] d;
      res = '0;
      if (c == CHAR_DOT) begin
         close_field();
         if (fin) str_bad = 1'b1;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = 4'(c - CHAR_ZERO);
         if (cur_digits >= MAX_DIGITS) begin
            str_bad = 1'b1;
         end else begin
            if (cur_digits == 0) cur_lead_zero = (d == 0);
            else if (cur_lead_zero) str_bad = 1'b1;
            cur_value  = OCTV_W'(cur_value * 10 + d);
            cur_digits = cur_digits + DCNT_W'(1);
         end
      end else begin
         str_bad = 1'b1;
      end
      if (!fin) return 1'b0;
      if (c != CHAR_DOT) close_field();
      res.valid_res = !str_bad && (fields_done == FIELD_COUNT);
      res.address   = res.valid_res ? addr_so_far : '0;
      fields_done = '0;
      addr_so_far = '0;
      str_bad     = 1'b0;
      return 1'b1;
   endfunction

   // Request side: predict on every accepted word
   always @(posedge clock) begin : req_mon
      rsp_word_type   pred;
      quad_check_type ref_entry;
      if (!reset && req_valid && req_ready) begin
         if (parse_char(req_ch, req_last, pred)) begin
            ref_entry = str_ref_q.pop_front();
            addr_expect_q.push_back(ref_entry.typed ? ref_entry.word : pred);
         end
      end
   end

   // Result side: compare with the oldest expectation
   always @(posedge clock) begin : rsp_mon
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (addr_expect_q.size() == 0) begin
            $error("unexpected result word: valid_res %0d address %08h",
                   rsp_valid_res, rsp_address);
            err_count++;
         end else begin
            want = addr_expect_q.pop_front();
            if (rsp_valid_res !== want.valid_res) begin
               $error("valid_res: expected %0d, got %0d", want.valid_res, rsp_valid_res);
               err_count++;
            end
            if (rsp_address !== want.address) begin
               $error("address: expected %08h, got %08h", want.address, rsp_address);
               err_count++;
            end
         end
      end
   end

   // Result-side backpressure in random bursts
   initial begin : rsp_side
      int unsigned n;
      wait (reset == 1'b0);
      forever begin
         if (recv_jitter && $urandom_range(0, 99) < 20) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 16);
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Send one word, with an optional idle burst first
   task automatic send_word(input logic [7:0] c, input logic fin);
      int unsigned n;
      if (send_jitter && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         n = $urandom_range(1, 16);
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      req_last  <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
   endtask

   // Send text_q as one string
   task automatic send_text(input bit typed, input rsp_word_type word);
      quad_check_type e;
      e.typed = typed;
      e.word  = word;
      str_ref_q.push_back(e);
      for (int i = 0; i < text_q.size(); i++)
         send_word(text_q[i], i == text_q.size() - 1);
   endtask

   // Hold off the sender until every expected word is back, once the last
   // accepted word has been predicted
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (addr_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic push_num(input int v);
      if (v >= 100) text_q.push_back(8'(CHAR_ZERO + v / 100));
      if (v >= 10) text_q.push_back(8'(CHAR_ZERO + (v / 10) % 10));
      text_q.push_back(8'(CHAR_ZERO + v % 10));
   endtask

   function automatic logic [7:0] foreign_char();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CHAR_DOT || (b >= CHAR_ZERO && b <= CHAR_NINE));
      return b;
   endfunction

   function automatic logic [7:0] noise_char();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 5) return 8'(CHAR_ZERO + $urandom_range(0, 9));
      if (r < 7) return CHAR_DOT;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int rand_octet();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 255 : 0;
      return $urandom_range(0, 255);
   endfunction

   // Mostly dotted quads (some with one flaw), else noise or long field runs
   task automatic gen_random_text();
      int unsigned kind, flaw, nf, bad_at, len;
      int v;
      text_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
         flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
         nf = 4;
         if (flaw == 1) nf = $urandom_range(1, 3);
         if (flaw == 2) nf = $urandom_range(5, 7);
         bad_at = $urandom_range(0, nf - 1);
         for (int f = 0; f < nf; f++) begin
            if (f > 0) text_q.push_back(CHAR_DOT);
            v = rand_octet();
            if (f == bad_at && flaw == 3) begin
               push_num($urandom_range(256, 999));
            end else if (f == bad_at && flaw == 4) begin
               // leading zero in a multi-digit field
               text_q.push_back(CHAR_ZERO);
               push_num(v);
            end else if (f == bad_at && flaw == 5) begin
               // empty field: nothing
            end else if (f == bad_at && flaw == 6) begin
               push_num($urandom_range(100, 255));
               text_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
            end else if (f == bad_at && flaw == 7) begin
               push_num(v);
               text_q.push_back(foreign_char());
            end else begin
               push_num(v);
            end
         end
         if (flaw == 8) text_q.push_back(CHAR_DOT);
      end else if (kind < 92) begin
         len = $urandom_range(1, 12);
         repeat (len) text_q.push_back(noise_char());
      end else begin
         // many fields, past the field counter limit
         nf = $urandom_range(5, 12);
         for (int f = 0; f < nf; f++) begin
            if (f > 0) text_q.push_back(CHAR_DOT);
            push_num(rand_octet());
         end
      end
   endtask

   // Watchdog
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stim
      int unsigned rand_start, n_str, guard;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed strings
      for (int r = 0; r < DIR_ROWS; r++) begin
         text_q.delete();
         for (int i = 0; i < dir_text[r].len(); i++) text_q.push_back(dir_text[r][i]);
         send_text(dir_typed[r], dir_rsp[r]);
      end
      wait_drained();

      // Random strings in phases of changing idle behavior
      rand_start = chars_sent;
      n_str = 0;
      while (chars_sent < rand_start + 2000) begin
         if (n_str % 40 == 0) begin
            if (chars_sent - rand_start > 1700) begin
               send_jitter = 1'b0;
               recv_jitter = 1'b0;
            end else begin
               send_jitter = ($urandom_range(0, 3) != 0);
               recv_jitter = ($urandom_range(0, 3) != 0);
               if ($urandom_range(0, 2) == 0) wait_drained();
            end
         end
         gen_random_text();
         send_text(1'b0, '0);
         n_str++;
      end

      // Drain, then allow for the pipeline latency
      req_valid <= 1'b0;
      @(posedge clock);
      guard = 0;
      while (addr_expect_q.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
      if (addr_expect_q.size() != 0) begin
         $error("%0d expected result words never arrived", addr_expect_q.size());
         err_count++;
      end
      if (err_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### ipv4_dotted_quad_parser.f
sv/ipv4dq_pkg.sv
sv/ipv4dq_in_stage.sv
sv/ipv4dq_core.sv
sv/ipv4dq_out_stage.sv
sv/ipv4_dotted_quad_parser.sv
sv/ipv4dq_checker.sv
tb/ipv4_dotted_quad_parser_tb.sv
